FILE: rtl/core/chip8_pkg.sv
// chip8_pkg: shared types, constants and the font table of the chip8 core
// used by chip8_alu and chip8_instruction_execute_core; no dependencies
`default_nettype none

package chip8_pkg;

    // sizes of the machine
    localparam int MEM_BYTES   = 4096;
    localparam int ADDR_W      = $clog2(MEM_BYTES);
    localparam int STACK_DEPTH = 16;
    localparam int STACK_IW    = $clog2(STACK_DEPTH);
    localparam int STACK_LW    = $clog2(STACK_DEPTH + 1);
    localparam int SCREEN_W    = 64;
    localparam int SCREEN_H    = 32;
    localparam int COL_W       = $clog2(SCREEN_W);
    localparam int ROW_W       = $clog2(SCREEN_H);
    localparam int NUM_REGS    = 16;
    localparam int FONT_BYTES  = 80;

    localparam logic [ADDR_W-1:0] FONT_BASE = 12'h050;
    localparam logic [ADDR_W-1:0] FONT_END  = 12'h0A0;
    localparam logic [ADDR_W-1:0] PC_RESET  = 12'h200;
    localparam logic [ADDR_W-1:0] ADDR_LAST = 12'hFFF;
    localparam logic [15:0]       I_LIMIT   = 16'h0FFF;
    localparam logic [15:0]       FONT_I    = 16'h0050;
    localparam logic [7:0]        HUNDRED   = 8'd100;
    localparam logic [7:0]        TEN       = 8'd10;
    localparam logic [3:0]        FLAG_REG  = 4'hF;

    // item modes
    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_EXEC = 2'd1,
        MODE_TICK = 2'd2,
        MODE_ROW  = 2'd3
    } t_mode;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_WAIT  = 2'd1,
        ST_OVER  = 2'd2,
        ST_UNDER = 2'd3
    } t_status;

    // opcode groups (top nibble)
    localparam logic [3:0] OP_SYS  = 4'h0;
    localparam logic [3:0] OP_JP   = 4'h1;
    localparam logic [3:0] OP_CALL = 4'h2;
    localparam logic [3:0] OP_SEI  = 4'h3;
    localparam logic [3:0] OP_SNEI = 4'h4;
    localparam logic [3:0] OP_SER  = 4'h5;
    localparam logic [3:0] OP_LDI  = 4'h6;
    localparam logic [3:0] OP_ADDI = 4'h7;
    localparam logic [3:0] OP_ALU  = 4'h8;
    localparam logic [3:0] OP_SNER = 4'h9;
    localparam logic [3:0] OP_LDIX = 4'hA;
    localparam logic [3:0] OP_JPV0 = 4'hB;
    localparam logic [3:0] OP_RND  = 4'hC;
    localparam logic [3:0] OP_DRW  = 4'hD;
    localparam logic [3:0] OP_KEY  = 4'hE;
    localparam logic [3:0] OP_MISC = 4'hF;

    // full or low-byte codes
    localparam logic [15:0] OP_CLS = 16'h00E0;
    localparam logic [15:0] OP_RET = 16'h00EE;
    localparam logic [7:0]  KEY_SKP  = 8'h9E;
    localparam logic [7:0]  KEY_SKNP = 8'hA1;
    localparam logic [7:0]  F_GETDT  = 8'h07;
    localparam logic [7:0]  F_WKEY   = 8'h0A;
    localparam logic [7:0]  F_SETDT  = 8'h15;
    localparam logic [7:0]  F_SETST  = 8'h18;
    localparam logic [7:0]  F_ADDI   = 8'h1E;
    localparam logic [7:0]  F_FONT   = 8'h29;
    localparam logic [7:0]  F_BCD    = 8'h33;
    localparam logic [7:0]  F_STORE  = 8'h55;
    localparam logic [7:0]  F_LOAD   = 8'h65;

    // 8XYN sub-codes
    localparam logic [3:0] A8_MOV = 4'h0;
    localparam logic [3:0] A8_OR  = 4'h1;
    localparam logic [3:0] A8_AND = 4'h2;
    localparam logic [3:0] A8_XOR = 4'h3;
    localparam logic [3:0] A8_ADD = 4'h4;
    localparam logic [3:0] A8_SUB = 4'h5;
    localparam logic [3:0] A8_SHR = 4'h6;
    localparam logic [3:0] A8_RSB = 4'h7;
    localparam logic [3:0] A8_SHL = 4'hE;

    // shared unit operations
    typedef enum logic [3:0] {
        ALU_PASS,
        ALU_OR,
        ALU_AND,
        ALU_XOR,
        ALU_ADD,
        ALU_SUB,
        ALU_RSUB,
        ALU_SHR,
        ALU_SHL
    } t_alu_op;

    typedef struct packed {
        logic [7:0] res;
        logic       flag;
        logic       eq;
        logic       ge;
    } t_alu_res;

    // sequencer states
    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_LOAD, S_TICK,
        S_F0, S_F1, S_F2, S_RX, S_RY, S_EX, S_WF,
        S_DR, S_DW, S_SR, S_SW, S_LR, S_LW,
        S_BH, S_BT, S_BO, S_DONE
    } t_state;

    localparam logic [7:0] FONT [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    // initial memory content at a given address
    function automatic logic [7:0] boot_byte(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] off;
        off = a - FONT_BASE;
        if (a >= FONT_BASE && a < FONT_END) begin
            return FONT[off[6:0]];
        end
        return 8'h00;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/chip8_ram.sv
// chip8_ram: generic one-write one-read ram with registered read data
// no dependencies
`default_nettype none

module chip8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/chip8_alu.sv
// chip8_alu: shared 8-bit arithmetic, logic, shift and compare unit
// depends on chip8_pkg
`default_nettype none

module chip8_alu (
    input  wire chip8_pkg::t_alu_op  i_op,
    input  wire logic [7:0]          i_a,
    input  wire logic [7:0]          i_b,
    output chip8_pkg::t_alu_res      o_res
);

    logic [8:0] sum;

    assign sum = {1'b0, i_a} + {1'b0, i_b};

    // result and flag per operation
    always_comb begin
        o_res.eq = (i_a == i_b);
        o_res.ge = (i_a >= i_b);
        unique case (i_op)
            chip8_pkg::ALU_PASS: begin
                o_res.res  = i_b;
                o_res.flag = 1'b0;
            end
            chip8_pkg::ALU_OR: begin
                o_res.res  = i_a | i_b;
                o_res.flag = 1'b0;
            end
            chip8_pkg::ALU_AND: begin
                o_res.res  = i_a & i_b;
                o_res.flag = 1'b0;
            end
            chip8_pkg::ALU_XOR: begin
                o_res.res  = i_a ^ i_b;
                o_res.flag = 1'b0;
            end
            chip8_pkg::ALU_ADD: begin
                o_res.res  = sum[7:0];
                o_res.flag = sum[8];
            end
            chip8_pkg::ALU_SUB: begin
                o_res.res  = i_a - i_b;
                o_res.flag = (i_a > i_b);
            end
            chip8_pkg::ALU_RSUB: begin
                o_res.res  = i_b - i_a;
                o_res.flag = (i_b > i_a);
            end
            chip8_pkg::ALU_SHR: begin
                o_res.res  = {1'b0, i_a[7:1]};
                o_res.flag = i_a[0];
            end
            chip8_pkg::ALU_SHL: begin
                o_res.res  = {i_a[6:0], 1'b0};
                o_res.flag = i_a[7];
            end
            default: begin
                o_res.res  = i_b;
                o_res.flag = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/chip8_instruction_execute_core.sv
// chip8_instruction_execute_core: top level of the chip8 machine core
// depends on chip8_pkg, chip8_ram and chip8_alu
`default_nettype none

// After reset the core writes the font and zeros into its main memory, one
// byte a cycle, and holds o_stall high until that pass ends. Then it takes one
// beat at a time. A memory load or tick goes through its own state and the done
// state before its result is registered; a row read, through the done state.
// An instruction takes two memory reads for the opcode, two register file reads
// and an execute state, plus a VF write where VF is set, a read and a write per
// sprite row for DXYN and per register for FX55 and FX65, and hundreds, tens and
// ones steps for FX33. All register and memory traffic goes through one-write
// one-read memories and one shared 8-bit ALU, so the step count follows from
// those ports. A finished result is held in an output register until taken.
module chip8_instruction_execute_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic [11:0] i_address,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_key_down,
    input  wire logic [3:0]  i_key_code,
    input  wire logic [7:0]  i_random_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [11:0]      o_program_counter,
    output logic [15:0]      o_index_value,
    output logic [1:0]       o_status,
    output logic             o_sound_on,
    output logic             o_frame_changed,
    output logic [63:0]      o_row_pixels
);

    localparam int AW = chip8_pkg::ADDR_W;
    localparam int SW = chip8_pkg::SCREEN_W;

    chip8_pkg::t_state  r_state, n_state;

    // latched input beat
    chip8_pkg::t_mode   r_mode;
    logic [AW-1:0]      r_addr;
    logic [7:0]         r_data;
    logic               r_kd;
    logic [3:0]         r_key;
    logic [7:0]         r_rnd;

    // machine state
    logic [AW-1:0]      r_pc, n_pc;
    logic [15:0]        r_i, n_i;
    logic [chip8_pkg::STACK_LW-1:0] r_level, n_level;
    logic [7:0]         r_delay, n_delay;
    logic [7:0]         r_sound, n_sound;
    logic [AW-1:0]      r_stack [chip8_pkg::STACK_DEPTH];
    logic [SW-1:0]      r_frame [chip8_pkg::SCREEN_H];
    logic [chip8_pkg::NUM_REGS-1:0] r_reg_ok;

    // working registers
    logic [15:0]        r_op, n_op;
    logic [7:0]         r_vx, n_vx;
    logic [7:0]         r_vy, n_vy;
    logic [3:0]         r_cnt, n_cnt;
    logic [3:0]         r_dig, n_dig;
    logic [7:0]         r_acc, n_acc;
    logic               r_hit, n_hit;
    logic               r_flag, n_flag;
    chip8_pkg::t_status r_st, n_st;
    logic               r_drew, n_drew;
    logic [AW-1:0]      r_clr;
    logic [3:0]         r_reg_ra;

    logic               r_out_valid;

    // memory and register file ports
    logic               mem_we;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    logic [7:0]         mem_wdata, mem_rdata;
    logic               reg_we;
    logic [3:0]         reg_waddr, reg_raddr;
    logic [7:0]         reg_wdata, reg_rdata, reg_val;

    // frame and stack controls
    logic               frame_clr, frame_we;
    logic [chip8_pkg::ROW_W-1:0] frame_row;
    logic [SW-1:0]      frame_wdata;
    logic               stack_we;

    // shared unit
    chip8_pkg::t_alu_op  alu_op;
    logic [7:0]          alu_a, alu_b;
    chip8_pkg::t_alu_res alu_res;

    // opcode fields and helpers
    logic [3:0]         op_grp, op_x, op_y, op_n;
    logic [7:0]         op_nn;
    logic [AW-1:0]      op_nnn;
    logic [AW-1:0]      pc_next, pc_skip, i_addr;
    logic [chip8_pkg::STACK_LW-1:0] level_m1;
    logic [15:0]        i_sum;
    logic [chip8_pkg::ROW_W-1:0] draw_row;
    logic [SW-1:0]      draw_mask;
    logic [2*SW-1:0]    draw_pair;
    logic               key_match, alu8_flagged, alu8_valid, ex_done;
    logic               in_beat, out_go;

    assign op_grp    = r_op[15:12];
    assign op_x      = r_op[11:8];
    assign op_y      = r_op[7:4];
    assign op_n      = r_op[3:0];
    assign op_nn     = r_op[7:0];
    assign op_nnn    = r_op[AW-1:0];
    assign pc_next   = r_pc + 12'd2;
    assign pc_skip   = r_pc + 12'd4;
    assign i_addr    = r_i[AW-1:0] + {8'h00, r_cnt};
    assign level_m1  = r_level - chip8_pkg::STACK_LW'(1);
    assign i_sum     = r_i + {8'h00, r_vx};
    assign reg_val   = r_reg_ok[r_reg_ra] ? reg_rdata : 8'h00;
    assign key_match = r_kd && alu_res.eq;
    assign in_beat   = i_valid && (r_state == chip8_pkg::S_IDLE);
    assign out_go    = !r_out_valid || !i_stall;

    // sprite byte spread over a row, wrapping at the right edge
    assign draw_row  = r_vy[chip8_pkg::ROW_W-1:0] + chip8_pkg::ROW_W'(r_cnt);
    assign draw_pair = {mem_rdata, {(SW-8){1'b0}}, mem_rdata, {(SW-8){1'b0}}}
                       >> r_vx[chip8_pkg::COL_W-1:0];
    assign draw_mask = draw_pair[SW-1:0];

    assign alu8_flagged = (op_n == chip8_pkg::A8_ADD) || (op_n == chip8_pkg::A8_SUB) ||
                          (op_n == chip8_pkg::A8_SHR) || (op_n == chip8_pkg::A8_RSB) ||
                          (op_n == chip8_pkg::A8_SHL);
    assign alu8_valid   = alu8_flagged || (op_n == chip8_pkg::A8_MOV) ||
                          (op_n == chip8_pkg::A8_OR) || (op_n == chip8_pkg::A8_AND) ||
                          (op_n == chip8_pkg::A8_XOR);

    // memories
    chip8_ram #(.WIDTH(8), .DEPTH(chip8_pkg::MEM_BYTES)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    chip8_ram #(.WIDTH(8), .DEPTH(chip8_pkg::NUM_REGS)) u_regs (
        .i_clk   (i_clk),
        .i_we    (reg_we),
        .i_waddr (reg_waddr),
        .i_wdata (reg_wdata),
        .i_raddr (reg_raddr),
        .o_rdata (reg_rdata)
    );

    chip8_alu u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res)
    );

    // alu operand selection
    always_comb begin
        alu_op = chip8_pkg::ALU_PASS;
        alu_a  = r_vx;
        alu_b  = r_vy;
        priority if (r_state == chip8_pkg::S_BH) begin
            alu_a  = r_acc;
            alu_b  = chip8_pkg::HUNDRED;
            alu_op = chip8_pkg::ALU_SUB;
        end else if (r_state == chip8_pkg::S_BT) begin
            alu_a  = r_acc;
            alu_b  = chip8_pkg::TEN;
            alu_op = chip8_pkg::ALU_SUB;
        end else begin
            unique case (op_grp)
                chip8_pkg::OP_SEI, chip8_pkg::OP_SNEI, chip8_pkg::OP_LDI: begin
                    alu_b = op_nn;
                end
                chip8_pkg::OP_ADDI: begin
                    alu_b  = op_nn;
                    alu_op = chip8_pkg::ALU_ADD;
                end
                chip8_pkg::OP_RND: begin
                    alu_a  = r_rnd;
                    alu_b  = op_nn;
                    alu_op = chip8_pkg::ALU_AND;
                end
                chip8_pkg::OP_KEY: begin
                    alu_b = {4'h0, r_key};
                end
                chip8_pkg::OP_ALU: begin
                    unique case (op_n)
                        chip8_pkg::A8_OR:  alu_op = chip8_pkg::ALU_OR;
                        chip8_pkg::A8_AND: alu_op = chip8_pkg::ALU_AND;
                        chip8_pkg::A8_XOR: alu_op = chip8_pkg::ALU_XOR;
                        chip8_pkg::A8_ADD: alu_op = chip8_pkg::ALU_ADD;
                        chip8_pkg::A8_SUB: alu_op = chip8_pkg::ALU_SUB;
                        chip8_pkg::A8_SHR: alu_op = chip8_pkg::ALU_SHR;
                        chip8_pkg::A8_RSB: alu_op = chip8_pkg::ALU_RSUB;
                        chip8_pkg::A8_SHL: alu_op = chip8_pkg::ALU_SHL;
                        default:           alu_op = chip8_pkg::ALU_PASS;
                    endcase
                end
                default: begin
                    alu_op = chip8_pkg::ALU_PASS;
                end
            endcase
        end
    end

    // execute cycle ends the instruction unless a follow-up sequence is needed
    always_comb begin
        ex_done = 1'b1;
        if (op_grp == chip8_pkg::OP_ALU && alu8_flagged) begin
            ex_done = 1'b0;
        end
        if (op_grp == chip8_pkg::OP_DRW) begin
            ex_done = 1'b0;
        end
        if (op_grp == chip8_pkg::OP_MISC &&
            (op_nn == chip8_pkg::F_ADDI || op_nn == chip8_pkg::F_BCD ||
             op_nn == chip8_pkg::F_STORE || op_nn == chip8_pkg::F_LOAD)) begin
            ex_done = 1'b0;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            chip8_pkg::S_CLR: begin
                if (r_clr == chip8_pkg::ADDR_LAST) n_state = chip8_pkg::S_IDLE;
            end
            chip8_pkg::S_IDLE: begin
                if (i_valid) begin
                    unique case (chip8_pkg::t_mode'(i_mode))
                        chip8_pkg::MODE_LOAD: n_state = chip8_pkg::S_LOAD;
                        chip8_pkg::MODE_EXEC: n_state = chip8_pkg::S_F0;
                        chip8_pkg::MODE_TICK: n_state = chip8_pkg::S_TICK;
                        default:              n_state = chip8_pkg::S_DONE;
                    endcase
                end
            end
            chip8_pkg::S_LOAD, chip8_pkg::S_TICK: n_state = chip8_pkg::S_DONE;
            chip8_pkg::S_F0: n_state = chip8_pkg::S_F1;
            chip8_pkg::S_F1: n_state = chip8_pkg::S_F2;
            chip8_pkg::S_F2: n_state = chip8_pkg::S_RX;
            chip8_pkg::S_RX: n_state = chip8_pkg::S_RY;
            chip8_pkg::S_RY: n_state = chip8_pkg::S_EX;
            chip8_pkg::S_EX: begin
                priority if (ex_done) begin
                    n_state = chip8_pkg::S_DONE;
                end else if (op_grp == chip8_pkg::OP_DRW) begin
                    n_state = (op_n == 4'h0) ? chip8_pkg::S_WF : chip8_pkg::S_DR;
                end else if (op_grp == chip8_pkg::OP_ALU || op_nn == chip8_pkg::F_ADDI) begin
                    n_state = chip8_pkg::S_WF;
                end else if (op_nn == chip8_pkg::F_BCD) begin
                    n_state = chip8_pkg::S_BH;
                end else if (op_nn == chip8_pkg::F_STORE) begin
                    n_state = chip8_pkg::S_SR;
                end else begin
                    n_state = chip8_pkg::S_LR;
                end
            end
            chip8_pkg::S_WF: n_state = chip8_pkg::S_DONE;
            chip8_pkg::S_DR: n_state = chip8_pkg::S_DW;
            chip8_pkg::S_DW: begin
                n_state = (r_cnt == op_n - 4'h1) ? chip8_pkg::S_WF : chip8_pkg::S_DR;
            end
            chip8_pkg::S_SR: n_state = chip8_pkg::S_SW;
            chip8_pkg::S_SW: begin
                n_state = (r_cnt == op_x) ? chip8_pkg::S_DONE : chip8_pkg::S_SR;
            end
            chip8_pkg::S_LR: n_state = chip8_pkg::S_LW;
            chip8_pkg::S_LW: begin
                n_state = (r_cnt == op_x) ? chip8_pkg::S_DONE : chip8_pkg::S_LR;
            end
            chip8_pkg::S_BH: if (!alu_res.ge) n_state = chip8_pkg::S_BT;
            chip8_pkg::S_BT: if (!alu_res.ge) n_state = chip8_pkg::S_BO;
            chip8_pkg::S_BO: n_state = chip8_pkg::S_DONE;
            chip8_pkg::S_DONE: if (out_go) n_state = chip8_pkg::S_IDLE;
            default: n_state = chip8_pkg::S_IDLE;
        endcase
    end

    // datapath controls and next values
    always_comb begin
        n_pc     = r_pc;
        n_i      = r_i;
        n_level  = r_level;
        n_delay  = r_delay;
        n_sound  = r_sound;
        n_op     = r_op;
        n_vx     = r_vx;
        n_vy     = r_vy;
        n_cnt    = r_cnt;
        n_dig    = r_dig;
        n_acc    = r_acc;
        n_hit    = r_hit;
        n_flag   = r_flag;
        n_st     = r_st;
        n_drew   = r_drew;

        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = r_data;
        mem_raddr = r_pc;
        reg_we    = 1'b0;
        reg_waddr = op_x;
        reg_wdata = alu_res.res;
        reg_raddr = op_x;
        frame_clr   = 1'b0;
        frame_we    = 1'b0;
        frame_row   = draw_row;
        frame_wdata = r_frame[draw_row] ^ draw_mask;
        stack_we    = 1'b0;

        unique case (r_state)
            chip8_pkg::S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = chip8_pkg::boot_byte(r_clr);
            end
            chip8_pkg::S_IDLE: begin
                n_st   = chip8_pkg::ST_OK;
                n_drew = 1'b0;
            end
            chip8_pkg::S_LOAD: begin
                mem_we = 1'b1;
            end
            chip8_pkg::S_TICK: begin
                if (r_delay != 8'h00) n_delay = r_delay - 8'h01;
                if (r_sound != 8'h00) n_sound = r_sound - 8'h01;
            end
            chip8_pkg::S_F0: begin
                mem_raddr = r_pc;
            end
            chip8_pkg::S_F1: begin
                mem_raddr     = pc_next - 12'd1;
                n_op[15:8]    = mem_rdata;
            end
            chip8_pkg::S_F2: begin
                n_op[7:0] = mem_rdata;
                reg_raddr = r_op[11:8];
            end
            chip8_pkg::S_RX: begin
                n_vx      = reg_val;
                reg_raddr = (op_grp == chip8_pkg::OP_JPV0) ? 4'h0 : op_y;
            end
            chip8_pkg::S_RY: begin
                n_vy = reg_val;
            end
            chip8_pkg::S_EX: begin
                n_pc  = pc_next;
                n_cnt = 4'h0;
                unique case (op_grp)
                    chip8_pkg::OP_SYS: begin
                        if (r_op == chip8_pkg::OP_CLS) begin
                            frame_clr = 1'b1;
                            n_drew    = 1'b1;
                        end else if (r_op == chip8_pkg::OP_RET) begin
                            if (r_level == '0) begin
                                n_st = chip8_pkg::ST_UNDER;
                            end else begin
                                n_level = level_m1;
                                n_pc    = r_stack[level_m1[chip8_pkg::STACK_IW-1:0]]
                                          + 12'd2;
                            end
                        end
                    end
                    chip8_pkg::OP_JP: n_pc = op_nnn;
                    chip8_pkg::OP_CALL: begin
                        if (r_level >= chip8_pkg::STACK_LW'(chip8_pkg::STACK_DEPTH)) begin
                            n_st = chip8_pkg::ST_OVER;
                        end else begin
                            stack_we = 1'b1;
                            n_level  = r_level + chip8_pkg::STACK_LW'(1);
                            n_pc     = op_nnn;
                        end
                    end
                    chip8_pkg::OP_SEI, chip8_pkg::OP_SER: begin
                        if (alu_res.eq) n_pc = pc_skip;
                    end
                    chip8_pkg::OP_SNEI, chip8_pkg::OP_SNER: begin
                        if (!alu_res.eq) n_pc = pc_skip;
                    end
                    chip8_pkg::OP_LDI, chip8_pkg::OP_ADDI, chip8_pkg::OP_RND: begin
                        reg_we = 1'b1;
                    end
                    chip8_pkg::OP_ALU: begin
                        reg_we = alu8_valid;
                        n_flag = alu_res.flag;
                    end
                    chip8_pkg::OP_LDIX: n_i = {4'h0, op_nnn};
                    chip8_pkg::OP_JPV0: n_pc = op_nnn + {4'h0, r_vy};
                    chip8_pkg::OP_DRW: begin
                        n_drew = 1'b1;
                        n_hit  = 1'b0;
                        n_flag = 1'b0;
                    end
                    chip8_pkg::OP_KEY: begin
                        if (op_nn == chip8_pkg::KEY_SKP && key_match) n_pc = pc_skip;
                        if (op_nn == chip8_pkg::KEY_SKNP && !key_match) n_pc = pc_skip;
                    end
                    default: begin
                        unique case (op_nn)
                            chip8_pkg::F_GETDT: begin
                                reg_we    = 1'b1;
                                reg_wdata = r_delay;
                            end
                            chip8_pkg::F_WKEY: begin
                                if (r_kd) begin
                                    reg_we    = 1'b1;
                                    reg_wdata = {4'h0, r_key};
                                end else begin
                                    n_st = chip8_pkg::ST_WAIT;
                                    n_pc = r_pc;
                                end
                            end
                            chip8_pkg::F_SETDT: n_delay = r_vx;
                            chip8_pkg::F_SETST: n_sound = r_vx;
                            chip8_pkg::F_ADDI: begin
                                n_i    = i_sum;
                                n_flag = (i_sum > chip8_pkg::I_LIMIT);
                            end
                            chip8_pkg::F_FONT: begin
                                n_i = chip8_pkg::FONT_I + ({8'h00, r_vx} << 2) + {8'h00, r_vx};
                            end
                            chip8_pkg::F_BCD: begin
                                n_acc = r_vx;
                                n_dig = 4'h0;
                            end
                            default: begin
                            end
                        endcase
                    end
                endcase
            end
            chip8_pkg::S_WF: begin
                reg_we    = 1'b1;
                reg_waddr = chip8_pkg::FLAG_REG;
                reg_wdata = {7'h00, r_flag};
            end
            chip8_pkg::S_DR: begin
                mem_raddr = i_addr;
            end
            chip8_pkg::S_DW: begin
                frame_we = 1'b1;
                n_hit    = r_hit || ((r_frame[draw_row] & draw_mask) != '0);
                n_flag   = n_hit;
                n_cnt    = r_cnt + 4'h1;
            end
            chip8_pkg::S_SR: begin
                reg_raddr = r_cnt;
            end
            chip8_pkg::S_SW: begin
                mem_we    = 1'b1;
                mem_waddr = i_addr;
                mem_wdata = reg_val;
                n_cnt     = r_cnt + 4'h1;
            end
            chip8_pkg::S_LR: begin
                mem_raddr = i_addr;
            end
            chip8_pkg::S_LW: begin
                reg_we    = 1'b1;
                reg_waddr = r_cnt;
                reg_wdata = mem_rdata;
                n_cnt     = r_cnt + 4'h1;
            end
            chip8_pkg::S_BH, chip8_pkg::S_BT: begin
                if (alu_res.ge) begin
                    n_acc = alu_res.res;
                    n_dig = r_dig + 4'h1;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = (r_state == chip8_pkg::S_BH) ? r_i[AW-1:0]
                                                             : r_i[AW-1:0] + 12'd1;
                    mem_wdata = {4'h0, r_dig};
                    n_dig     = 4'h0;
                end
            end
            chip8_pkg::S_BO: begin
                mem_we    = 1'b1;
                mem_waddr = r_i[AW-1:0] + 12'd2;
                mem_wdata = r_acc;
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= chip8_pkg::S_CLR;
            r_clr       <= '0;
            r_pc        <= chip8_pkg::PC_RESET;
            r_i         <= '0;
            r_level     <= '0;
            r_delay     <= '0;
            r_sound     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= r_clr + 12'd1;
            r_pc    <= n_pc;
            r_i     <= n_i;
            r_level <= n_level;
            r_delay <= n_delay;
            r_sound <= n_sound;
            if (r_state == chip8_pkg::S_DONE && out_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // register file valid bits, frame rows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_ok <= '0;
            for (int r = 0; r < chip8_pkg::SCREEN_H; r++) begin
                r_frame[r] <= '0;
            end
        end else begin
            if (reg_we) r_reg_ok[reg_waddr] <= 1'b1;
            if (frame_clr) begin
                for (int r = 0; r < chip8_pkg::SCREEN_H; r++) begin
                    r_frame[r] <= '0;
                end
            end else if (frame_we) begin
                r_frame[frame_row] <= frame_wdata;
            end
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_mode <= chip8_pkg::t_mode'(i_mode);
            r_addr <= i_address;
            r_data <= i_data_byte;
            r_kd   <= i_key_down;
            r_key  <= i_key_code;
            r_rnd  <= i_random_byte;
        end
        if (stack_we) r_stack[r_level[chip8_pkg::STACK_IW-1:0]] <= r_pc;
        r_op     <= n_op;
        r_vx     <= n_vx;
        r_vy     <= n_vy;
        r_cnt    <= n_cnt;
        r_dig    <= n_dig;
        r_acc    <= n_acc;
        r_hit    <= n_hit;
        r_flag   <= n_flag;
        r_st     <= n_st;
        r_drew   <= n_drew;
        r_reg_ra <= reg_raddr;
    end

    // result beat
    always_ff @(posedge i_clk) begin
        if (r_state == chip8_pkg::S_DONE && out_go) begin
            o_program_counter <= r_pc;
            o_index_value     <= r_i;
            o_status          <= r_st;
            o_sound_on        <= (r_sound != 8'h00);
            o_frame_changed   <= r_drew;
            if (r_mode == chip8_pkg::MODE_ROW &&
                r_addr < AW'(chip8_pkg::SCREEN_H)) begin
                o_row_pixels <= r_frame[r_addr[chip8_pkg::ROW_W-1:0]];
            end else begin
                o_row_pixels <= '0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_stall = (r_state != chip8_pkg::S_IDLE);

endmodule

`default_nettype wire
